>>> rtl/core/epf_pkg.sv
// Shared types and codes for the Euler path finder.
package epf_pkg;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_SOLVE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_CLEAR = 2'd3;

   localparam logic [2:0] STAT_STORED   = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_FOUND    = 3'd2;
   localparam logic [2:0] STAT_NO_PATH  = 3'd3;
   localparam logic [2:0] STAT_VERTEX   = 3'd4;
   localparam logic [2:0] STAT_PAST_END = 3'd5;

   typedef enum logic [5:0] {
      ST_IDLE, ST_RD_WAIT,
      ST_CHK_RE, ST_CHK_EV, ST_ZD,
      ST_DG_RE, ST_DG_RA, ST_DG_QA, ST_DG_WA, ST_DG_QB, ST_DG_WB,
      ST_OD_RE, ST_OD_EV, ST_AJ_RE, ST_AJ_EV,
      ST_OF_INIT, ST_OF_RE, ST_OF_WR,
      ST_IN_RE, ST_IN_RA, ST_IN_QA, ST_IN_WA, ST_IN_QB, ST_IN_WB,
      ST_SR_RE, ST_SR_WR,
      ST_WK_LD, ST_WK_PE, ST_WK_CHK, ST_WK_ID, ST_WK_US, ST_WK_ED, ST_WK_POP,
      ST_UC_RE, ST_UC_EV, ST_RT_RE, ST_RT_EV
   } state_type;

endpackage

>>> rtl/core/epf_if.sv
// Request and response channel interfaces.
interface epf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [8:0] edge_from;
   logic [8:0] edge_to;
   modport source (output valid, kind, edge_from, edge_to, input ready);
   modport sink   (input valid, kind, edge_from, edge_to, output ready);
endinterface

interface epf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [8:0]  path_vertex;
   logic [10:0] path_length;
   logic        last;
   modport source (output valid, status, path_vertex, path_length, last, input ready);
   modport sink   (input valid, status, path_vertex, path_length, last, output ready);
endinterface

>>> rtl/core/euler_path_finder.sv
// Euler path finder top level: edge store, Hierholzer walk sequencer, path readout.
//
//   channel  | dir | payload
//   req_if   | in  | kind, edge_from, edge_to
//   rsp_if   | out | status, path_vertex, path_length, last
//   csr_*    | in  | vertex_count write
//
// Add and clear are answered from idle; read waits on the registered path memory read.
// Solve per edge: range check, degree count, incidence fill, used check, and adjacency
// with two odd vertices; the walk steps over edges, skipped entries and pops. Per vertex:
// zero degrees, odd search, offsets and rewind. One item is in work at a time.
// Reset is synchronous; memories are not cleared, solve rebuilds all it reads but the edge store.
// A result waiting on rsp_if blocks a new item only until it is taken.
module euler_path_finder
   import epf_pkg::*;
#(
   parameter int MAX_VERTICES = 256,
   parameter int MAX_EDGES    = 1024
) (
   input  logic       clock,
   input  logic       reset,
   epf_req_if.sink    req_if,
   epf_rsp_if.source  rsp_if,
   input  logic       csr_we,
   input  logic [8:0] csr_wdata
);
   localparam int NW   = $clog2(MAX_VERTICES + 1);
   localparam int VIW  = $clog2(MAX_VERTICES);
   localparam int CW   = $clog2(MAX_EDGES + 3);
   localparam int EIW  = $clog2(MAX_EDGES + 1);
   localparam int LIW  = $clog2(2 * MAX_EDGES + 2);
   localparam int OW   = $clog2(2 * MAX_EDGES + 3);
   localparam int PIW  = $clog2(MAX_EDGES + 2);
   localparam int CMPW = (NW > 9) ? NW : 9;

   // memory ports
   logic            edge_we;   logic [EIW-1:0] edge_waddr; logic [17:0]   edge_wdata;
   logic [EIW-1:0]  edge_raddr; logic [17:0]   edge_rdata;
   logic            deg_we;    logic [VIW-1:0] deg_waddr;  logic [OW-1:0] deg_wdata;
   logic [VIW-1:0]  deg_raddr;  logic [OW-1:0] deg_rdata;
   logic            off_we;    logic [NW-1:0]  off_waddr;  logic [OW-1:0] off_wdata;
   logic [NW-1:0]   off_raddr;  logic [OW-1:0] off_rdata;
   logic            inc_we;    logic [LIW-1:0] inc_waddr;  logic [EIW-1:0] inc_wdata;
   logic [LIW-1:0]  inc_raddr;  logic [EIW-1:0] inc_rdata;
   logic            scan_we;   logic [VIW-1:0] scan_waddr; logic [OW-1:0] scan_wdata;
   logic [VIW-1:0]  scan_raddr; logic [OW-1:0] scan_rdata;
   logic            used_we;   logic [EIW-1:0] used_waddr; logic [0:0]    used_wdata;
   logic [EIW-1:0]  used_raddr; logic [0:0]    used_rdata;
   logic            stk_we;    logic [PIW-1:0] stk_waddr;  logic [8:0]    stk_wdata;
   logic [PIW-1:0]  stk_raddr;  logic [8:0]    stk_rdata;
   logic            path_we;   logic [PIW-1:0] path_waddr; logic [8:0]    path_wdata;
   logic [PIW-1:0]  path_raddr; logic [8:0]    path_rdata;

   epf_ram #(.DEPTH(MAX_EDGES + 1), .WIDTH(18)) u_edge (
      .clock, .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
      .raddr(edge_raddr), .rdata(edge_rdata));
   epf_ram #(.DEPTH(MAX_VERTICES), .WIDTH(OW)) u_deg (
      .clock, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
      .raddr(deg_raddr), .rdata(deg_rdata));
   epf_ram #(.DEPTH(MAX_VERTICES + 1), .WIDTH(OW)) u_off (
      .clock, .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
      .raddr(off_raddr), .rdata(off_rdata));
   epf_ram #(.DEPTH(2 * MAX_EDGES + 2), .WIDTH(EIW)) u_inc (
      .clock, .we(inc_we), .waddr(inc_waddr), .wdata(inc_wdata),
      .raddr(inc_raddr), .rdata(inc_rdata));
   epf_ram #(.DEPTH(MAX_VERTICES), .WIDTH(OW)) u_scan (
      .clock, .we(scan_we), .waddr(scan_waddr), .wdata(scan_wdata),
      .raddr(scan_raddr), .rdata(scan_rdata));
   epf_ram #(.DEPTH(MAX_EDGES + 1), .WIDTH(1)) u_used (
      .clock, .we(used_we), .waddr(used_waddr), .wdata(used_wdata),
      .raddr(used_raddr), .rdata(used_rdata));
   epf_ram #(.DEPTH(MAX_EDGES + 2), .WIDTH(9)) u_stk (
      .clock, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .raddr(stk_raddr), .rdata(stk_rdata));
   epf_ram #(.DEPTH(MAX_EDGES + 2), .WIDTH(9)) u_path (
      .clock, .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
      .raddr(path_raddr), .rdata(path_rdata));

   state_type     st_ff, st_in;
   logic [8:0]    vcount_ff, vcount_in;
   logic [CW-1:0] edge_count_ff, edge_count_in;
   logic [CW-1:0] path_count_ff, path_count_in;
   logic [CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] e_ff, e_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] base_ff, base_in;
   logic [CW-1:0] split_ff, split_in;
   logic [NW-1:0] v_ff, v_in;
   logic [8:0]    a_ff, a_in, b_ff, b_in;
   logic [8:0]    v1_ff, v1_in, v2_ff, v2_in, start_ff, start_in;
   logic [8:0]    u_ff, u_in, prev_ff, prev_in;
   logic [1:0]    nodd_ff, nodd_in;
   logic          added_ff, added_in, art_ff, art_in;
   logic [OW-1:0] sum_ff, sum_in, p_ff, p_in, end_ff, end_in;
   logic [EIW-1:0] id_ff, id_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [8:0]    rsp_vertex_ff, rsp_vertex_in;
   logic [10:0]   rsp_length_ff, rsp_length_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          req_fire, rsp_load, rsp_last_new;
   logic [2:0]    rsp_stat_new;
   logic [8:0]    rsp_vtx_new, ea, eb, w;
   logic [CMPW-1:0] n_cmp;
   logic [NW-1:0] n_eff;
   logic [CW-1:0] rd_idx;

   assign req_if.ready       = (st_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_fire           = req_if.valid && req_if.ready;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.path_vertex = rsp_vertex_ff;
   assign rsp_if.path_length = rsp_length_ff;
   assign rsp_if.last        = rsp_last_ff;

   assign n_cmp = (CMPW'(vcount_ff) > CMPW'(MAX_VERTICES)) ? CMPW'(MAX_VERTICES)
                                                            : CMPW'(vcount_ff);
   assign n_eff = NW'(n_cmp);
   assign ea    = edge_rdata[17:9];
   assign eb    = edge_rdata[8:0];
   assign w     = (ea == u_ff) ? eb : ea;
   assign rd_idx = (rd_ptr_ff < split_ff) ? rd_ptr_ff + base_ff
                                          : rd_ptr_ff - split_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         vcount_ff     <= 9'd1;
         edge_count_ff <= '0;
         path_count_ff <= '0;
         rd_ptr_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         st_ff         <= st_in;
         vcount_ff     <= vcount_in;
         edge_count_ff <= edge_count_in;
         path_count_ff <= path_count_in;
         rd_ptr_ff     <= rd_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      e_ff          <= e_in;
      total_ff      <= total_in;
      sp_ff         <= sp_in;
      cnt_ff        <= cnt_in;
      base_ff       <= base_in;
      split_ff      <= split_in;
      v_ff          <= v_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      v1_ff         <= v1_in;
      v2_ff         <= v2_in;
      start_ff      <= start_in;
      u_ff          <= u_in;
      prev_ff       <= prev_in;
      nodd_ff       <= nodd_in;
      added_ff      <= added_in;
      art_ff        <= art_in;
      sum_ff        <= sum_in;
      p_ff          <= p_in;
      end_ff        <= end_in;
      id_ff         <= id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_length_ff <= rsp_length_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      st_in = st_ff;
      vcount_in = csr_we ? csr_wdata : vcount_ff;
      edge_count_in = edge_count_ff; path_count_in = path_count_ff; rd_ptr_in = rd_ptr_ff;
      e_in = e_ff; total_in = total_ff; sp_in = sp_ff; cnt_in = cnt_ff;
      base_in = base_ff; split_in = split_ff; v_in = v_ff;
      a_in = a_ff; b_in = b_ff; v1_in = v1_ff; v2_in = v2_ff; start_in = start_ff;
      u_in = u_ff; prev_in = prev_ff; nodd_in = nodd_ff;
      added_in = added_ff; art_in = art_ff;
      sum_in = sum_ff; p_in = p_ff; end_in = end_ff; id_in = id_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff; rsp_vertex_in = rsp_vertex_ff;
      rsp_length_in = rsp_length_ff; rsp_last_in = rsp_last_ff;
      rsp_load = 1'b0; rsp_stat_new = STAT_STORED; rsp_vtx_new = '0; rsp_last_new = 1'b0;

      edge_we = 1'b0; edge_waddr = '0; edge_wdata = '0; edge_raddr = '0;
      deg_we  = 1'b0; deg_waddr  = '0; deg_wdata  = '0; deg_raddr  = '0;
      off_we  = 1'b0; off_waddr  = '0; off_wdata  = '0; off_raddr  = '0;
      inc_we  = 1'b0; inc_waddr  = '0; inc_wdata  = '0; inc_raddr  = '0;
      scan_we = 1'b0; scan_waddr = '0; scan_wdata = '0; scan_raddr = '0;
      used_we = 1'b0; used_waddr = '0; used_wdata = '0; used_raddr = '0;
      stk_we  = 1'b0; stk_waddr  = '0; stk_wdata  = '0; stk_raddr  = '0;
      path_we = 1'b0; path_waddr = '0; path_wdata = '0; path_raddr = '0;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_if.kind)
                  KIND_ADD: begin
                     rsp_load = 1'b1;
                     if (edge_count_ff < CW'(MAX_EDGES)) begin
                        edge_we = 1'b1;
                        edge_waddr = edge_count_ff[EIW-1:0];
                        edge_wdata = {req_if.edge_from, req_if.edge_to};
                        edge_count_in = edge_count_ff + 1'b1;
                        rsp_stat_new = STAT_STORED;
                     end else begin
                        rsp_stat_new = STAT_FULL;
                     end
                  end
                  KIND_SOLVE: begin
                     path_count_in = '0;
                     rd_ptr_in = '0;
                     if (edge_count_ff == '0) begin
                        rsp_load = 1'b1;
                        rsp_stat_new = STAT_NO_PATH;
                     end else begin
                        e_in = '0;
                        st_in = ST_CHK_RE;
                     end
                  end
                  KIND_READ: begin
                     if (rd_ptr_ff < path_count_ff) begin
                        path_raddr = rd_idx[PIW-1:0];
                        st_in = ST_RD_WAIT;
                     end else begin
                        rsp_load = 1'b1;
                        rsp_stat_new = STAT_PAST_END;
                     end
                  end
                  KIND_CLEAR: begin
                     edge_count_in = '0;
                     path_count_in = '0;
                     rd_ptr_in = '0;
                     rsp_load = 1'b1;
                     rsp_stat_new = STAT_STORED;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            rsp_load = 1'b1;
            rsp_stat_new = STAT_VERTEX;
            rsp_vtx_new = path_rdata;
            rsp_last_new = (rd_ptr_ff + 1'b1 == path_count_ff);
            rd_ptr_in = rd_ptr_ff + 1'b1;
            st_in = ST_IDLE;
         end
         // endpoint range check
         ST_CHK_RE: begin
            edge_raddr = e_ff[EIW-1:0];
            st_in = ST_CHK_EV;
         end
         ST_CHK_EV: begin
            if (ea == '0 || eb == '0 || CMPW'(ea) > n_cmp || CMPW'(eb) > n_cmp) begin
               rsp_load = 1'b1;
               rsp_stat_new = STAT_NO_PATH;
               st_in = ST_IDLE;
            end else if (e_ff + 1'b1 == edge_count_ff) begin
               v_in = '0;
               st_in = ST_ZD;
            end else begin
               e_in = e_ff + 1'b1;
               st_in = ST_CHK_RE;
            end
         end
         ST_ZD: begin
            deg_we = 1'b1;
            deg_waddr = v_ff[VIW-1:0];
            deg_wdata = '0;
            v_in = v_ff + 1'b1;
            if (v_ff + 1'b1 == n_eff) begin
               e_in = '0;
               art_in = 1'b0;
               st_in = ST_DG_RE;
            end
         end
         // degree count
         ST_DG_RE: begin
            edge_raddr = e_ff[EIW-1:0];
            st_in = ST_DG_RA;
         end
         ST_DG_RA: begin
            a_in = ea;
            b_in = eb;
            st_in = ST_DG_QA;
         end
         ST_DG_QA: begin
            deg_raddr = VIW'(a_ff - 9'd1);
            st_in = ST_DG_WA;
         end
         ST_DG_WA: begin
            deg_we = 1'b1;
            deg_waddr = VIW'(a_ff - 9'd1);
            deg_wdata = deg_rdata + 1'b1;
            st_in = ST_DG_QB;
         end
         ST_DG_QB: begin
            deg_raddr = VIW'(b_ff - 9'd1);
            st_in = ST_DG_WB;
         end
         ST_DG_WB: begin
            deg_we = 1'b1;
            deg_waddr = VIW'(b_ff - 9'd1);
            deg_wdata = deg_rdata + 1'b1;
            if (art_ff) begin
               st_in = ST_OF_INIT;
            end else if (e_ff + 1'b1 == edge_count_ff) begin
               v_in = '0;
               nodd_in = '0;
               v1_in = '0;
               v2_in = '0;
               start_in = '0;
               st_in = ST_OD_RE;
            end else begin
               e_in = e_ff + 1'b1;
               st_in = ST_DG_RE;
            end
         end
         // odd vertex and start search
         ST_OD_RE: begin
            deg_raddr = v_ff[VIW-1:0];
            st_in = ST_OD_EV;
         end
         ST_OD_EV: begin
            if (deg_rdata[0]) begin
               if (nodd_ff == 2'd0) v1_in = 9'(v_ff + 1'b1);
               if (nodd_ff == 2'd1) v2_in = 9'(v_ff + 1'b1);
               if (nodd_ff != 2'd3) nodd_in = nodd_ff + 1'b1;
            end
            if (start_ff == '0 && deg_rdata != '0) start_in = 9'(v_ff + 1'b1);
            v_in = v_ff + 1'b1;
            st_in = ST_OD_RE;
            if (v_ff + 1'b1 == n_eff) begin
               total_in = edge_count_ff;
               added_in = 1'b0;
               e_in = '0;
               if (nodd_in == 2'd3) begin
                  rsp_load = 1'b1;
                  rsp_stat_new = STAT_NO_PATH;
                  st_in = ST_IDLE;
               end else if (v1_in != '0) begin
                  start_in = v1_in;
                  st_in = ST_AJ_RE;
               end else begin
                  st_in = ST_OF_INIT;
               end
            end
         end
         // adjacency of the odd pair
         ST_AJ_RE: begin
            edge_raddr = e_ff[EIW-1:0];
            st_in = ST_AJ_EV;
         end
         ST_AJ_EV: begin
            if ((ea == v1_ff && eb == v2_ff) || (ea == v2_ff && eb == v1_ff)) begin
               st_in = ST_OF_INIT;
            end else if (e_ff + 1'b1 == edge_count_ff) begin
               edge_we = 1'b1;
               edge_waddr = edge_count_ff[EIW-1:0];
               edge_wdata = {v1_ff, v2_ff};
               total_in = edge_count_ff + 1'b1;
               added_in = 1'b1;
               art_in = 1'b1;
               a_in = v1_ff;
               b_in = v2_ff;
               st_in = ST_DG_QA;
            end else begin
               e_in = e_ff + 1'b1;
               st_in = ST_AJ_RE;
            end
         end
         // prefix sums of degree
         ST_OF_INIT: begin
            off_we = 1'b1;
            off_waddr = '0;
            off_wdata = '0;
            sum_in = '0;
            v_in = '0;
            st_in = ST_OF_RE;
         end
         ST_OF_RE: begin
            deg_raddr = v_ff[VIW-1:0];
            st_in = ST_OF_WR;
         end
         ST_OF_WR: begin
            off_we = 1'b1;
            off_waddr = NW'(v_ff + 1'b1);
            off_wdata = sum_ff + deg_rdata;
            scan_we = 1'b1;
            scan_waddr = v_ff[VIW-1:0];
            scan_wdata = sum_ff;
            sum_in = sum_ff + deg_rdata;
            v_in = v_ff + 1'b1;
            st_in = ST_OF_RE;
            if (v_ff + 1'b1 == n_eff) begin
               e_in = '0;
               st_in = ST_IN_RE;
            end
         end
         // incidence list fill
         ST_IN_RE: begin
            edge_raddr = e_ff[EIW-1:0];
            used_we = 1'b1;
            used_waddr = e_ff[EIW-1:0];
            used_wdata = 1'b0;
            st_in = ST_IN_RA;
         end
         ST_IN_RA: begin
            a_in = ea;
            b_in = eb;
            st_in = ST_IN_QA;
         end
         ST_IN_QA: begin
            scan_raddr = VIW'(a_ff - 9'd1);
            st_in = ST_IN_WA;
         end
         ST_IN_WA: begin
            inc_we = 1'b1;
            inc_waddr = LIW'(scan_rdata);
            inc_wdata = e_ff[EIW-1:0];
            scan_we = 1'b1;
            scan_waddr = VIW'(a_ff - 9'd1);
            scan_wdata = scan_rdata + 1'b1;
            st_in = ST_IN_QB;
         end
         ST_IN_QB: begin
            scan_raddr = VIW'(b_ff - 9'd1);
            st_in = ST_IN_WB;
         end
         ST_IN_WB: begin
            inc_we = 1'b1;
            inc_waddr = LIW'(scan_rdata);
            inc_wdata = e_ff[EIW-1:0];
            scan_we = 1'b1;
            scan_waddr = VIW'(b_ff - 9'd1);
            scan_wdata = scan_rdata + 1'b1;
            e_in = e_ff + 1'b1;
            st_in = ST_IN_RE;
            if (e_ff + 1'b1 == total_ff) begin
               v_in = '0;
               st_in = ST_SR_RE;
            end
         end
         // rewind scan pointers
         ST_SR_RE: begin
            off_raddr = v_ff;
            st_in = ST_SR_WR;
         end
         ST_SR_WR: begin
            scan_we = 1'b1;
            scan_waddr = v_ff[VIW-1:0];
            scan_wdata = off_rdata;
            v_in = v_ff + 1'b1;
            st_in = ST_SR_RE;
            if (v_ff + 1'b1 == n_eff) begin
               stk_we = 1'b1;
               stk_waddr = '0;
               stk_wdata = start_ff;
               sp_in = CW'(1);
               cnt_in = '0;
               u_in = start_ff;
               st_in = ST_WK_LD;
            end
         end
         // stack walk
         ST_WK_LD: begin
            scan_raddr = VIW'(u_ff - 9'd1);
            off_raddr = NW'(u_ff);
            st_in = ST_WK_PE;
         end
         ST_WK_PE: begin
            p_in = scan_rdata;
            end_in = off_rdata;
            st_in = ST_WK_CHK;
         end
         ST_WK_CHK: begin
            if (p_ff < end_ff) begin
               inc_raddr = LIW'(p_ff);
               st_in = ST_WK_ID;
            end else begin
               scan_we = 1'b1;
               scan_waddr = VIW'(u_ff - 9'd1);
               scan_wdata = p_ff;
               path_we = 1'b1;
               path_waddr = cnt_ff[PIW-1:0];
               path_wdata = u_ff;
               cnt_in = cnt_ff + 1'b1;
               sp_in = sp_ff - 1'b1;
               if (sp_ff == CW'(1)) begin
                  e_in = '0;
                  st_in = ST_UC_RE;
               end else begin
                  stk_raddr = PIW'(sp_ff - CW'(2));
                  st_in = ST_WK_POP;
               end
            end
         end
         ST_WK_ID: begin
            id_in = inc_rdata;
            used_raddr = inc_rdata;
            st_in = ST_WK_US;
         end
         ST_WK_US: begin
            if (used_rdata[0]) begin
               p_in = p_ff + 1'b1;
               st_in = ST_WK_CHK;
            end else begin
               scan_we = 1'b1;
               scan_waddr = VIW'(u_ff - 9'd1);
               scan_wdata = p_ff;
               used_we = 1'b1;
               used_waddr = id_ff;
               used_wdata = 1'b1;
               edge_raddr = id_ff;
               st_in = ST_WK_ED;
            end
         end
         ST_WK_ED: begin
            stk_we = 1'b1;
            stk_waddr = sp_ff[PIW-1:0];
            stk_wdata = w;
            sp_in = sp_ff + 1'b1;
            u_in = w;
            st_in = ST_WK_LD;
         end
         ST_WK_POP: begin
            u_in = stk_rdata;
            st_in = ST_WK_LD;
         end
         // every edge used?
         ST_UC_RE: begin
            used_raddr = e_ff[EIW-1:0];
            st_in = ST_UC_EV;
         end
         ST_UC_EV: begin
            if (!used_rdata[0]) begin
               rsp_load = 1'b1;
               rsp_stat_new = STAT_NO_PATH;
               st_in = ST_IDLE;
            end else if (e_ff + 1'b1 == total_ff) begin
               base_in = '0;
               split_in = cnt_ff;
               if (added_ff) begin
                  e_in = '0;
                  st_in = ST_RT_RE;
               end else begin
                  path_count_in = cnt_ff;
                  rsp_load = 1'b1;
                  rsp_stat_new = STAT_FOUND;
                  st_in = ST_IDLE;
               end
            end else begin
               e_in = e_ff + 1'b1;
               st_in = ST_UC_RE;
            end
         end
         // find the artificial edge; rotation is applied by readout addressing
         ST_RT_RE: begin
            path_raddr = e_ff[PIW-1:0];
            st_in = ST_RT_EV;
         end
         ST_RT_EV: begin
            prev_in = path_rdata;
            e_in = e_ff + 1'b1;
            st_in = ST_RT_RE;
            if (e_ff != '0 && ((prev_ff == v1_ff && path_rdata == v2_ff) ||
                                (prev_ff == v2_ff && path_rdata == v1_ff))) begin
               base_in = e_ff;
               split_in = cnt_ff - e_ff;
               path_count_in = cnt_ff - 1'b1;
               rsp_load = 1'b1;
               rsp_stat_new = STAT_FOUND;
               st_in = ST_IDLE;
            end else if (e_ff + 1'b1 == cnt_ff) begin
               path_count_in = cnt_ff;
               rsp_load = 1'b1;
               rsp_stat_new = STAT_FOUND;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase

      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = rsp_stat_new;
         rsp_vertex_in = rsp_vtx_new;
         rsp_last_in   = rsp_last_new;
         rsp_length_in = 11'(path_count_in);
      end
   end

   a_rd_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      rd_ptr_ff <= path_count_ff)
      else $error("read pointer past path length");

   a_vertex_has_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STAT_VERTEX |-> rsp_length_ff != '0)
      else $error("vertex returned with empty path");

   a_walk_stack_live: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_WK_CHK |-> sp_ff != '0)
      else $error("walk on empty stack");
endmodule

>>> rtl/core/epf_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
module epf_ram #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 1
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
